// ----- src/cldma_pkg.sv -----
`default_nettype none
package cldma_pkg;
  localparam int AddrBits = 20;

  localparam logic [1:0] KIND_REG_WR = 2'd0;
  localparam logic [1:0] KIND_REG_RD = 2'd1;
  localparam logic [1:0] KIND_RD_DATA = 2'd2;
  localparam logic [1:0] KIND_WR_DONE = 2'd3;

  localparam logic [1:0] OP_MEM_RD = 2'd0;
  localparam logic [1:0] OP_MEM_WR = 2'd1;
  localparam logic [1:0] OP_REG_DATA = 2'd2;
  localparam logic [1:0] OP_DONE = 2'd3;

  localparam logic [1:0] CMD_COPY = 2'd0;
  localparam logic [1:0] CMD_MIX = 2'd1;
  localparam logic [1:0] CMD_SWAP = 2'd2;
  localparam logic [1:0] CMD_FILL = 2'd3;

  localparam logic [3:0] DESC_BYTES = 4'd11;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] reg_index;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        io_space;
    logic [19:0] address;
    logic [7:0]  data;
  } result_t;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_LIST    = 6'b000010,
    PH_SRC_RD  = 6'b000100,
    PH_TGT_RD  = 6'b001000,
    PH_SWAP_WR = 6'b010000,
    PH_WR_WAIT = 6'b100000
  } phase_t;
endpackage
`default_nettype wire

// ----- src/cldma_queue.sv -----
`default_nettype none
// two-entry item queue between front and back
module cldma_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  cldma_pkg::item_t     in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output cldma_pkg::item_t     out_item
);
  cldma_pkg::item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- src/cldma_back.sv -----
`default_nettype none
// descriptor sequencer: one queued item per cycle unless the result is held, result into output register
module cldma_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  item_valid,
  output logic                 item_ready,
  input  cldma_pkg::item_t     item,
  output logic                 res_valid,
  input  wire                  res_ready,
  output cldma_pkg::result_t   res
);
  localparam logic [19:0] PtrMask = 20'((64'd1 << cldma_pkg::AddrBits) - 64'd1);

  cldma_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  areg0_r, areg1_r, areg2_r, areg0_nxt, areg1_nxt, areg2_nxt;
  logic [19:0] lp_r, lp_nxt;
  logic [3:0]  dcnt_r, dcnt_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [23:0] src_r, src_nxt, tgt_r, tgt_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        rv_r, rv_nxt;
  cldma_pkg::result_t res_r, res_nxt;
  logic        take;
  logic [3:0]  dcnt_inc;

  assign item_ready = !rv_r || res_ready;
  assign take = item_valid && item_ready;
  assign res_valid = rv_r;
  assign res = res_r;
  assign dcnt_inc = dcnt_r + 4'd1;

  function automatic cldma_pkg::result_t req(logic [1:0] op, logic [23:0] p, logic [7:0] d);
    cldma_pkg::result_t r;
    r.op = op;
    r.data = d;
    if (p[23]) begin
      r.io_space = 1'b1;
      r.address = {8'h0D, p[11:0]};
    end else begin
      r.io_space = 1'b0;
      r.address = p[19:0] & PtrMask;
    end
    return r;
  endfunction

  function automatic logic [23:0] step_ptr(logic [23:0] p);
    logic [19:0] lo;
    lo = p[19:0] & PtrMask;
    if (p[20]) return p;
    if (p[22]) lo = (lo - 20'd1) & PtrMask;
    else lo = (lo + 20'd1) & PtrMask;
    return {p[23:20], lo};
  endfunction

  function automatic logic [7:0] mix(logic [7:0] c, logic [7:0] s, logic [7:0] t);
    return ({8{c[4]}} & ~s & ~t) | ({8{c[5]}} & ~s & t) |
           ({8{c[6]}} & s & ~t) | ({8{c[7]}} & s & t);
  endfunction

  always_comb begin
    logic [15:0] ln;
    logic [7:0]  cm;
    logic        adv;
    phase_nxt = phase_r;
    areg0_nxt = areg0_r; areg1_nxt = areg1_r; areg2_nxt = areg2_r;
    lp_nxt = lp_r; dcnt_nxt = dcnt_r; cmd_nxt = cmd_r; len_nxt = len_r;
    src_nxt = src_r; tgt_nxt = tgt_r; held_nxt = held_r;
    rv_nxt = rv_r && !res_ready;
    res_nxt = res_r;
    ln = len_r;
    cm = cmd_r;
    adv = 1'b0;
    if (take) begin
      unique case (item.kind)
        cldma_pkg::KIND_REG_WR: begin
          if (phase_r == cldma_pkg::PH_IDLE && item.reg_index != 2'd3) begin
            case (item.reg_index)
              2'd0: areg0_nxt = item.data;
              2'd1: areg1_nxt = item.data;
              default: areg2_nxt = item.data;
            endcase
            if (item.reg_index == 2'd0) begin
              lp_nxt = {areg2_r[3:0], areg1_r, item.data} & PtrMask;
              dcnt_nxt = 4'd0;
              phase_nxt = cldma_pkg::PH_LIST;
              rv_nxt = 1'b1;
              res_nxt = '{cldma_pkg::OP_MEM_RD, 1'b0,
                          {areg2_r[3:0], areg1_r, item.data} & PtrMask, 8'd0};
            end
          end
        end
        cldma_pkg::KIND_REG_RD: begin
          if (phase_r == cldma_pkg::PH_IDLE) begin
            rv_nxt = 1'b1;
            res_nxt = '{cldma_pkg::OP_REG_DATA, 1'b0, 20'd0,
                        (item.reg_index == 2'd3) ? 8'h00 : 8'hFF};
          end
        end
        cldma_pkg::KIND_RD_DATA: begin
          if (phase_r == cldma_pkg::PH_LIST) begin
            case (dcnt_r)
              4'd0: begin cmd_nxt = item.data; cm = item.data; end
              4'd1: begin ln = {8'd0, item.data}; len_nxt = ln; end
              4'd2: begin ln = {item.data, len_r[7:0]}; len_nxt = ln; end
              4'd3: src_nxt = {16'd0, item.data};
              4'd4: src_nxt[15:8] = item.data;
              4'd5: src_nxt[23:16] = item.data;
              4'd6: tgt_nxt = {16'd0, item.data};
              4'd7: tgt_nxt[15:8] = item.data;
              4'd8: tgt_nxt[23:16] = item.data;
              default: ;
            endcase
            lp_nxt = (lp_r + 20'd1) & PtrMask;
            if (dcnt_inc < cldma_pkg::DESC_BYTES) begin
              dcnt_nxt = dcnt_inc;
              rv_nxt = 1'b1;
              res_nxt = '{cldma_pkg::OP_MEM_RD, 1'b0, lp_nxt, 8'd0};
            end else begin
              dcnt_nxt = 4'd0;
              adv = 1'b1;
            end
          end else if (phase_r == cldma_pkg::PH_SRC_RD) begin
            rv_nxt = 1'b1;
            if (cmd_r[1:0] == cldma_pkg::CMD_COPY) begin
              phase_nxt = cldma_pkg::PH_WR_WAIT;
              res_nxt = req(cldma_pkg::OP_MEM_WR, tgt_r, item.data);
            end else begin
              held_nxt = item.data;
              phase_nxt = cldma_pkg::PH_TGT_RD;
              res_nxt = req(cldma_pkg::OP_MEM_RD, tgt_r, 8'd0);
            end
          end else if (phase_r == cldma_pkg::PH_TGT_RD) begin
            rv_nxt = 1'b1;
            if (cmd_r[1:0] == cldma_pkg::CMD_MIX) begin
              phase_nxt = cldma_pkg::PH_WR_WAIT;
              res_nxt = req(cldma_pkg::OP_MEM_WR, tgt_r, mix(cmd_r, held_r, item.data));
            end else begin
              phase_nxt = cldma_pkg::PH_SWAP_WR;
              res_nxt = req(cldma_pkg::OP_MEM_WR, src_r, item.data);
            end
          end
        end
        default: begin
          if (phase_r == cldma_pkg::PH_SWAP_WR) begin
            phase_nxt = cldma_pkg::PH_WR_WAIT;
            rv_nxt = 1'b1;
            res_nxt = req(cldma_pkg::OP_MEM_WR, tgt_r, held_r);
          end else if (phase_r == cldma_pkg::PH_WR_WAIT) begin
            if (cmd_r[1:0] != cldma_pkg::CMD_FILL) src_nxt = step_ptr(src_r);
            tgt_nxt = step_ptr(tgt_r);
            adv = 1'b1;
          end
        end
      endcase
      // next element, next descriptor or list done
      if (adv) begin
        rv_nxt = 1'b1;
        if (ln == 16'd0) begin
          if (cm[2]) begin
            dcnt_nxt = 4'd0;
            phase_nxt = cldma_pkg::PH_LIST;
            res_nxt = '{cldma_pkg::OP_MEM_RD, 1'b0, lp_nxt, 8'd0};
          end else begin
            phase_nxt = cldma_pkg::PH_IDLE;
            res_nxt = '{cldma_pkg::OP_DONE, 1'b0, 20'd0, 8'd0};
          end
        end else begin
          len_nxt = ln - 16'd1;
          if (cm[1:0] == cldma_pkg::CMD_FILL) begin
            phase_nxt = cldma_pkg::PH_WR_WAIT;
            res_nxt = req(cldma_pkg::OP_MEM_WR, tgt_nxt, src_nxt[7:0]);
          end else begin
            phase_nxt = cldma_pkg::PH_SRC_RD;
            res_nxt = req(cldma_pkg::OP_MEM_RD, src_nxt, 8'd0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cldma_pkg::PH_IDLE;
      areg0_r <= '0; areg1_r <= '0; areg2_r <= '0;
      lp_r <= '0; dcnt_r <= '0; cmd_r <= '0; len_r <= '0;
      src_r <= '0; tgt_r <= '0; held_r <= '0;
      rv_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      areg0_r <= areg0_nxt; areg1_r <= areg1_nxt; areg2_r <= areg2_nxt;
      lp_r <= lp_nxt; dcnt_r <= dcnt_nxt; cmd_r <= cmd_nxt; len_r <= len_nxt;
      src_r <= src_nxt; tgt_r <= tgt_nxt; held_r <= held_nxt;
      rv_r <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end
endmodule
`default_nettype wire

// ----- src/chained_list_dma_engine_top.sv -----
`default_nettype none
// Chained descriptor DMA engine. Register accesses, memory read data and
// write-done answers enter as items; the engine replies with memory read or
// write requests, register read data, or a list-finished mark. Items pass
// through a two-entry queue into the descriptor sequencer, which handles one
// item per cycle while its output register is free or being taken; each item
// is registered in the queue, and its answer in the output register.
module chained_list_dma_engine_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [1:0]  in_tuser,   // kind[1:0]
  input  wire  [15:0] in_tdata,   // reg_index[1:0], data_in[9:2], zero pad
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [2:0]  out_tuser,  // op[1:0], io_space[2]
  output logic [31:0] out_tdata   // address[19:0], data_out[27:20], zero pad
);
  cldma_pkg::item_t   in_item, q_item;
  cldma_pkg::result_t res;
  logic q_valid, q_ready;

  assign in_item = '{in_tuser, in_tdata[1:0], in_tdata[9:2]};

  cldma_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_item(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  cldma_back u_back (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tuser = {res.io_space, res.op};
  assign out_tdata = {4'd0, res.data, res.address};
endmodule
`default_nettype wire
